/* rtl/nsq_pkg.sv */
package nsq_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ATLAS_W = 2'd0,
    CFG_ATLAS_H = 2'd1,
    CFG_FILL    = 2'd2,
    CFG_SLICED  = 2'd3
  } nsq_cfg_e;

  // one classified draw handed from the front end to the quad emitter
  typedef struct packed {
    logic        simple;
    logic        fill;
    logic [23:0] rx;
    logic [23:0] ry;
    logic [22:0] rw;
    logic [22:0] rh;
    logic [16:0] tu;
    logic [16:0] tv;
    logic [16:0] tw;
    logic [16:0] th;
    logic [22:0] dl;
    logic [22:0] dr;
    logic [22:0] dt;
    logic [22:0] db;
    logic [16:0] ul;
    logic [16:0] ur;
    logic [16:0] vt;
    logic [16:0] vb;
    logic [15:0] hu;
    logic [15:0] hv;
  } nsq_cmd_t;

  // one emitted result
  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [22:0] w;
    logic [22:0] h;
    logic [16:0] u;
    logic [16:0] v;
    logic [16:0] uw;
    logic [16:0] vh;
    logic        present;
    logic        last;
  } nsq_res_t;

endpackage

/* rtl/nsq_div.sv */
module nsq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import nsq_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs_q;
  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_d;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, quo_q[31]};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[63:32];
      quo_q <= dividend_i[31:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/nsq_front.sv */
module nsq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [23:0]   rect_x_i,
  input  logic signed [23:0]   rect_y_i,
  input  logic [22:0]          rect_w_i,
  input  logic [22:0]          rect_h_i,
  input  logic [16:0]          uv_u_i,
  input  logic [16:0]          uv_v_i,
  input  logic [16:0]          uv_w_i,
  input  logic [16:0]          uv_h_i,
  input  logic signed [23:0]   border_left_i,
  input  logic signed [23:0]   border_top_i,
  input  logic signed [23:0]   border_right_i,
  input  logic signed [23:0]   border_bottom_i,
  input  logic [14:0]          atlas_w_i,
  input  logic [14:0]          atlas_h_i,
  input  logic                 fill_i,
  input  logic                 sliced_i,
  output logic                 div_start_o,
  output logic [63:0]          div_dividend_o,
  output logic [31:0]          div_divisor_o,
  input  logic                 div_done_i,
  input  logic [31:0]          div_quot_i,
  input  logic                 full_i,
  output logic                 push_o,
  output nsq_pkg::nsq_cmd_t    cmd_o
);
  import nsq_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE, F_SIZE, F_CHK, F_OP, F_DST, F_DIV, F_PUSH
  } fstate_e;

  localparam logic [3:0] OP_L  = 4'd0;
  localparam logic [3:0] OP_R  = 4'd1;
  localparam logic [3:0] OP_T  = 4'd2;
  localparam logic [3:0] OP_B  = 4'd3;
  localparam logic [3:0] OP_DL = 4'd4;
  localparam logic [3:0] OP_DR = 4'd5;
  localparam logic [3:0] OP_DT = 4'd6;
  localparam logic [3:0] OP_DB = 4'd7;
  localparam logic [3:0] OP_UL = 4'd8;
  localparam logic [3:0] OP_UR = 4'd9;
  localparam logic [3:0] OP_VT = 4'd10;
  localparam logic [3:0] OP_VB = 4'd11;
  localparam logic [3:0] OP_HU = 4'd12;
  localparam logic [3:0] OP_HV = 4'd13;
  localparam logic [31:0] HALF_TEXEL = 32'd32768;

  fstate_e     state_q;
  logic [3:0]  op_q;
  logic [23:0] rx_q, ry_q;
  logic [22:0] rw_q, rh_q;
  logic [16:0] tu_q, tv_q, tw_q, th_q;
  logic [31:0] s_q [4];
  logic [31:0] spw_q, sph_q;
  logic [63:0] prod_q;
  logic [31:0] dvs_q;
  logic [31:0] res_q [14];
  logic        simple_q;

  logic [31:0] sum_lr, sum_tb;
  logic [23:0] dsum_x, dsum_y;
  logic [31:0] op_a, op_b, op_dvs;
  logic        op_en;
  logic        simple_c;

  // pair sums for the clamps, and the check for a simple draw
  always_comb begin
    sum_lr = s_q[0] + s_q[1];
    sum_tb = s_q[2] + s_q[3];
    dsum_x = {1'b0, res_q[0][30:8]} + {1'b0, res_q[1][30:8]};
    dsum_y = {1'b0, res_q[2][30:8]} + {1'b0, res_q[3][30:8]};
    simple_c = !sliced_i || (spw_q == '0) || (sph_q == '0);
  end

  // operand selection per step: result = a * b / divisor when enabled, else a
  always_comb begin
    op_a   = '0;
    op_b   = 32'd1;
    op_dvs = 32'd1;
    op_en  = 1'b0;
    case (op_q)
      OP_L: begin
        op_a = s_q[0]; op_b = spw_q; op_dvs = sum_lr; op_en = (sum_lr > spw_q);
      end
      OP_R: begin
        op_a = s_q[1]; op_b = spw_q; op_dvs = sum_lr; op_en = (sum_lr > spw_q);
      end
      OP_T: begin
        op_a = s_q[2]; op_b = sph_q; op_dvs = sum_tb; op_en = (sum_tb > sph_q);
      end
      OP_B: begin
        op_a = s_q[3]; op_b = sph_q; op_dvs = sum_tb; op_en = (sum_tb > sph_q);
      end
      OP_DL: begin
        op_a = 32'(res_q[0][30:8]); op_b = 32'(rw_q); op_dvs = 32'(dsum_x);
        op_en = (dsum_x > {1'b0, rw_q});
      end
      OP_DR: begin
        op_a = 32'(res_q[1][30:8]); op_b = 32'(rw_q); op_dvs = 32'(dsum_x);
        op_en = (dsum_x > {1'b0, rw_q});
      end
      OP_DT: begin
        op_a = 32'(res_q[2][30:8]); op_b = 32'(rh_q); op_dvs = 32'(dsum_y);
        op_en = (dsum_y > {1'b0, rh_q});
      end
      OP_DB: begin
        op_a = 32'(res_q[3][30:8]); op_b = 32'(rh_q); op_dvs = 32'(dsum_y);
        op_en = (dsum_y > {1'b0, rh_q});
      end
      OP_UL: begin
        op_a = res_q[0]; op_dvs = 32'(atlas_w_i); op_en = 1'b1;
      end
      OP_UR: begin
        op_a = res_q[1]; op_dvs = 32'(atlas_w_i); op_en = 1'b1;
      end
      OP_VT: begin
        op_a = res_q[2]; op_dvs = 32'(atlas_h_i); op_en = 1'b1;
      end
      OP_VB: begin
        op_a = res_q[3]; op_dvs = 32'(atlas_h_i); op_en = 1'b1;
      end
      OP_HU: begin
        op_a = HALF_TEXEL; op_dvs = 32'(atlas_w_i); op_en = 1'b1;
      end
      OP_HV: begin
        op_a = HALF_TEXEL; op_dvs = 32'(atlas_h_i); op_en = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= OP_L;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (start_i) state_q <= F_SIZE;
        end
        F_SIZE: state_q <= F_CHK;
        F_CHK: begin
          op_q <= OP_L;
          state_q <= simple_c ? F_PUSH : F_OP;
        end
        F_OP: begin
          if (op_en) begin
            state_q <= F_DST;
          end else if (op_q == OP_HV) begin
            state_q <= F_PUSH;
          end else begin
            op_q <= op_q + 4'd1;
          end
        end
        F_DST: state_q <= F_DIV;
        F_DIV: begin
          if (div_done_i) begin
            if (op_q == OP_HV) begin
              state_q <= F_PUSH;
            end else begin
              op_q    <= op_q + 4'd1;
              state_q <= F_OP;
            end
          end
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      rx_q   <= rect_x_i;
      ry_q   <= rect_y_i;
      rw_q   <= rect_w_i;
      rh_q   <= rect_h_i;
      tu_q   <= uv_u_i;
      tv_q   <= uv_v_i;
      tw_q   <= uv_w_i;
      th_q   <= uv_h_i;
      s_q[0] <= border_left_i[23]   ? '0 : {1'b0, border_left_i[22:0], 8'b0};
      s_q[1] <= border_right_i[23]  ? '0 : {1'b0, border_right_i[22:0], 8'b0};
      s_q[2] <= border_top_i[23]    ? '0 : {1'b0, border_top_i[22:0], 8'b0};
      s_q[3] <= border_bottom_i[23] ? '0 : {1'b0, border_bottom_i[22:0], 8'b0};
    end
    if (state_q == F_SIZE) begin
      spw_q <= 32'(tw_q) * 32'(atlas_w_i);
      sph_q <= 32'(th_q) * 32'(atlas_h_i);
    end
    if (state_q == F_CHK) simple_q <= simple_c;
    if (state_q == F_OP) begin
      prod_q <= {32'b0, op_a} * {32'b0, op_b};
      dvs_q  <= op_dvs;
      if (!op_en) res_q[op_q] <= op_a;
    end
    if (state_q == F_DIV && div_done_i) res_q[op_q] <= div_quot_i;
  end

  assign busy_o         = (state_q != F_IDLE);
  assign div_start_o    = (state_q == F_DST);
  assign div_dividend_o = prod_q;
  assign div_divisor_o  = dvs_q;
  assign push_o         = (state_q == F_PUSH) && !full_i;

  // request to the emitter
  always_comb begin
    cmd_o.simple = simple_q;
    cmd_o.fill   = fill_i;
    cmd_o.rx     = rx_q;
    cmd_o.ry     = ry_q;
    cmd_o.rw     = rw_q;
    cmd_o.rh     = rh_q;
    cmd_o.tu     = tu_q;
    cmd_o.tv     = tv_q;
    cmd_o.tw     = tw_q;
    cmd_o.th     = th_q;
    cmd_o.dl     = res_q[OP_DL][22:0];
    cmd_o.dr     = res_q[OP_DR][22:0];
    cmd_o.dt     = res_q[OP_DT][22:0];
    cmd_o.db     = res_q[OP_DB][22:0];
    cmd_o.ul     = res_q[OP_UL][16:0];
    cmd_o.ur     = res_q[OP_UR][16:0];
    cmd_o.vt     = res_q[OP_VT][16:0];
    cmd_o.vb     = res_q[OP_VB][16:0];
    cmd_o.hu     = res_q[OP_HU][15:0];
    cmd_o.hv     = res_q[OP_HV][15:0];
  end

endmodule

/* rtl/nsq_fifo.sv */
module nsq_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nsq_pkg::nsq_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output nsq_pkg::nsq_cmd_t data_o,
  output logic              empty_o
);
  import nsq_pkg::*;

  nsq_cmd_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign data_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

/* rtl/nsq_back.sv */
module nsq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  nsq_pkg::nsq_cmd_t cmd_i,
  output logic              pop_o,
  output logic              valid_o,
  output nsq_pkg::nsq_res_t res_o
);
  import nsq_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_FLUSH} bstate_e;

  bstate_e  state_q;
  logic [1:0] row_q, col_q;
  logic     pend_vld_q;
  logic     out_vld_q;
  nsq_cmd_t cmd_q;
  nsq_res_t pend_q;
  nsq_res_t out_q;
  nsq_res_t cell_res;
  nsq_res_t simple_res;
  nsq_res_t flush_res;

  logic [23:0]        cx, cy;
  logic signed [24:0] cw, ch;
  logic [16:0]        cu, cv;
  logic signed [18:0] cuw, cvh;
  logic signed [18:0] hu2, hv2;
  logic               keep;
  logic               center;

  // column edges and spans
  always_comb begin
    case (col_q)
      2'd0: begin
        cx  = cmd_q.rx;
        cw  = 25'(cmd_q.dl);
        cu  = cmd_q.tu;
        cuw = 19'(cmd_q.ul);
      end
      2'd1: begin
        cx  = cmd_q.rx + 24'(cmd_q.dl);
        cw  = 25'(cmd_q.rw) - 25'(cmd_q.dl) - 25'(cmd_q.dr);
        cu  = cmd_q.tu + cmd_q.ul;
        cuw = 19'(cmd_q.tw) - 19'(cmd_q.ul) - 19'(cmd_q.ur);
      end
      default: begin
        cx  = cmd_q.rx + 24'(cmd_q.rw) - 24'(cmd_q.dr);
        cw  = 25'(cmd_q.dr);
        cu  = cmd_q.tu + cmd_q.tw - cmd_q.ur;
        cuw = 19'(cmd_q.ur);
      end
    endcase
  end

  // row edges and spans
  always_comb begin
    case (row_q)
      2'd0: begin
        cy  = cmd_q.ry;
        ch  = 25'(cmd_q.dt);
        cv  = cmd_q.tv;
        cvh = 19'(cmd_q.vt);
      end
      2'd1: begin
        cy  = cmd_q.ry + 24'(cmd_q.dt);
        ch  = 25'(cmd_q.rh) - 25'(cmd_q.dt) - 25'(cmd_q.db);
        cv  = cmd_q.tv + cmd_q.vt;
        cvh = 19'(cmd_q.th) - 19'(cmd_q.vt) - 19'(cmd_q.vb);
      end
      default: begin
        cy  = cmd_q.ry + 24'(cmd_q.rh) - 24'(cmd_q.db);
        ch  = 25'(cmd_q.db);
        cv  = cmd_q.tv + cmd_q.th - cmd_q.vb;
        cvh = 19'(cmd_q.vb);
      end
    endcase
  end

  // cell result with half-texel inset
  always_comb begin
    hu2    = {2'b0, cmd_q.hu, 1'b0};
    hv2    = {2'b0, cmd_q.hv, 1'b0};
    center = (row_q == 2'd1) && (col_q == 2'd1);
    keep   = (cw > 25'sd0) && (ch > 25'sd0) && (cuw > 19'sd0) && (cvh > 19'sd0) &&
             !(center && !cmd_q.fill);
    cell_res.x       = cx;
    cell_res.y       = cy;
    cell_res.w       = cw[22:0];
    cell_res.h       = ch[22:0];
    cell_res.u       = cu;
    cell_res.uw      = cuw[16:0];
    cell_res.v       = cv;
    cell_res.vh      = cvh[16:0];
    if (cuw > hu2) begin
      cell_res.u  = cu + 17'(cmd_q.hu);
      cell_res.uw = 17'(cuw - hu2);
    end
    if (cvh > hv2) begin
      cell_res.v  = cv + 17'(cmd_q.hv);
      cell_res.vh = 17'(cvh - hv2);
    end
    cell_res.present = 1'b1;
    cell_res.last    = 1'b0;
  end

  // pass-through quad
  always_comb begin
    simple_res.x       = cmd_i.rx;
    simple_res.y       = cmd_i.ry;
    simple_res.w       = cmd_i.rw;
    simple_res.h       = cmd_i.rh;
    simple_res.u       = cmd_i.tu;
    simple_res.v       = cmd_i.tv;
    simple_res.uw      = cmd_i.tw;
    simple_res.vh      = cmd_i.th;
    simple_res.present = 1'b1;
    simple_res.last    = 1'b1;
  end

  // final result of a sliced draw, empty terminator when nothing was kept
  always_comb begin
    if (pend_vld_q) begin
      flush_res = pend_q;
    end else begin
      flush_res = '0;
    end
    flush_res.last = 1'b1;
  end

  assign pop_o = (state_q == B_IDLE) && !empty_i;

  // cell walk, one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            if (cmd_i.simple) begin
              out_vld_q <= 1'b1;
            end else begin
              state_q    <= B_SCAN;
              row_q      <= '0;
              col_q      <= '0;
              pend_vld_q <= 1'b0;
            end
          end
        end
        B_SCAN: begin
          out_vld_q <= keep && pend_vld_q;
          if (keep) pend_vld_q <= 1'b1;
          if (col_q == 2'd2) begin
            col_q <= '0;
            if (row_q == 2'd2) state_q <= B_FLUSH;
            else row_q <= row_q + 2'd1;
          end else begin
            col_q <= col_q + 2'd1;
          end
        end
        B_FLUSH: begin
          out_vld_q <= 1'b1;
          state_q   <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          cmd_q <= cmd_i;
          out_q <= simple_res;
        end
      end
      B_SCAN: begin
        if (keep) begin
          out_q  <= pend_q;
          pend_q <= cell_res;
        end
      end
      B_FLUSH: begin
        out_q <= flush_res;
      end
      default: begin
        out_q <= out_q;
      end
    endcase
  end

  assign valid_o = out_vld_q;
  assign res_o   = out_q;

endmodule

/* rtl/nine_slice_quad_generator_unit.sv */
// a simple draw skips the divider; a sliced draw runs 14 clamp/scale steps, each of
// which may use the shared 32-step divider; the front end takes a new draw once it
// has pushed the last one into the two-entry FIFO; results leave at most one per cycle,
// as the emitter walks the nine cells of a sliced draw and then flushes its last one
// reset: config returns to atlas 1024x1024, center fill on, sliced mode on
// the receiver cannot stall: valid_o is high for exactly one cycle per result
module nine_slice_quad_generator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [23:0]  rect_x_i,
  input  logic signed [23:0]  rect_y_i,
  input  logic [22:0]         rect_w_i,
  input  logic [22:0]         rect_h_i,
  input  logic [16:0]         uv_u_i,
  input  logic [16:0]         uv_v_i,
  input  logic [16:0]         uv_w_i,
  input  logic [16:0]         uv_h_i,
  input  logic signed [23:0]  border_left_i,
  input  logic signed [23:0]  border_top_i,
  input  logic signed [23:0]  border_right_i,
  input  logic signed [23:0]  border_bottom_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [14:0]         cfg_wdata_i,
  output logic                valid_o,
  output logic signed [23:0]  quad_x_o,
  output logic signed [23:0]  quad_y_o,
  output logic [22:0]         quad_w_o,
  output logic [22:0]         quad_h_o,
  output logic [16:0]         tex_u_o,
  output logic [16:0]         tex_v_o,
  output logic [16:0]         tex_w_o,
  output logic [16:0]         tex_h_o,
  output logic                quad_present_o,
  output logic                last_quad_o
);
  import nsq_pkg::*;

  logic [14:0] atlas_w_q, atlas_h_q;
  logic        fill_q, sliced_q;
  logic        div_start, div_done;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor, div_quot;
  logic        push, full, pop, empty;
  nsq_cmd_t    cmd_in, cmd_out;
  nsq_res_t    res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= 15'd1024;
      atlas_h_q <= 15'd1024;
      fill_q    <= 1'b1;
      sliced_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (nsq_cfg_e'(cfg_idx_i))
        CFG_ATLAS_W: atlas_w_q <= cfg_wdata_i;
        CFG_ATLAS_H: atlas_h_q <= cfg_wdata_i;
        CFG_FILL:    fill_q    <= cfg_wdata_i[0];
        CFG_SLICED:  sliced_q  <= cfg_wdata_i[0];
        default:     fill_q    <= fill_q;
      endcase
    end
  end

  nsq_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .rect_w_i        (rect_w_i),
    .rect_h_i        (rect_h_i),
    .uv_u_i          (uv_u_i),
    .uv_v_i          (uv_v_i),
    .uv_w_i          (uv_w_i),
    .uv_h_i          (uv_h_i),
    .border_left_i   (border_left_i),
    .border_top_i    (border_top_i),
    .border_right_i  (border_right_i),
    .border_bottom_i (border_bottom_i),
    .atlas_w_i       (atlas_w_q),
    .atlas_h_i       (atlas_h_q),
    .fill_i          (fill_q),
    .sliced_i        (sliced_q),
    .div_start_o     (div_start),
    .div_dividend_o  (div_dividend),
    .div_divisor_o   (div_divisor),
    .div_done_i      (div_done),
    .div_quot_i      (div_quot),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  nsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  nsq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  nsq_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .valid_o (valid_o),
    .res_o   (res)
  );

  assign quad_x_o       = res.x;
  assign quad_y_o       = res.y;
  assign quad_w_o       = res.w;
  assign quad_h_o       = res.h;
  assign tex_u_o        = res.u;
  assign tex_v_o        = res.v;
  assign tex_w_o        = res.uw;
  assign tex_h_o        = res.vh;
  assign quad_present_o = res.present;
  assign last_quad_o    = res.last;

endmodule

/* rtl/nsq_chk.sv */
module nsq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [22:0] quad_w_o,
  input logic [16:0] tex_w_o,
  input logic        quad_present_o,
  input logic        last_quad_o
);

  logic [3:0] cnt_q;

  // results since the last terminating one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (valid_o) begin
      cnt_q <= last_quad_o ? 4'd0 : cnt_q + 4'd1;
    end
  end

  // a taken request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after request");

  // an empty result ends its draw
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !quad_present_o) |-> last_quad_o)
    else $error("empty result without last");

  // an empty result carries no size
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !quad_present_o) |-> (quad_w_o == '0 && tex_w_o == '0))
    else $error("empty result with nonzero size");

  // at most nine results per draw
  a_max_nine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cnt_q < 4'd9))
    else $error("more than nine results in one draw");

endmodule

bind nine_slice_quad_generator_unit nsq_chk u_chk (.*);
